@@ design/chrt_pkg.sv @@
// ----------------------------------------------------------------------------
// chrt_pkg
// shared constants and types of the hash ring table
// ----------------------------------------------------------------------------
package chrt_pkg;

   localparam int CAPACITY   = 1024;
   localparam int IDX_W      = $clog2(CAPACITY);
   localparam int CNT_W      = $clog2(CAPACITY + 1);
   localparam int KEY_W      = 64;
   localparam int SRV_W      = 8;
   localparam int ENTRY_W    = KEY_W + SRV_W;

   typedef enum logic [1:0] {
      CMD_INSERT = 2'd0,
      CMD_REMOVE = 2'd1,
      CMD_FIND   = 2'd2,
      CMD_LOOKUP = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_FULL  = 2'd1,
      ST_EMPTY = 2'd2,
      ST_ZERO  = 2'd3
   } status_type;

endpackage

@@ design/chrt_ram.sv @@
// ----------------------------------------------------------------------------
// chrt_ram
// generic single port ram with registered read
// ----------------------------------------------------------------------------
module chrt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wr_data,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // read before write, read registered
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wr_data;
      end
      rd_data <= mem[addr];
   end

endmodule

@@ design/consistent_hash_ring_table.sv @@
// ----------------------------------------------------------------------------
// consistent_hash_ring_table
// sorted ring of hash points with insert, remove, find and successor lookup
// ----------------------------------------------------------------------------
// Usage: a transaction on the req_ channel carries command, key_hash and
// server_id; each one gives exactly one rsp_ transaction with the chosen
// server, the found key, the removed flag, a status and the entry count.
// Points are held sorted in one ram of key and server. Every command starts
// with a binary search, one probe per ram read; at 1024 points that is up to
// 11 probes. A lookup that wraps reads the first point after the search.
// Insert of a new key and remove then shift the entries above the position,
// one entry at a time. One transaction is handled at a time; req_stall is
// high while busy or while a response waits, and the next request is taken
// in the cycle after the response is accepted. The response is held in
// output registers while rsp_stall is high. Reset empties the table at once
// (the count goes to zero); ram contents are never cleared, only entries
// below the count are used.
// ----------------------------------------------------------------------------
module consistent_hash_ring_table (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_command,
   input  logic [63:0] req_key_hash,
   input  logic [7:0]  req_server_id,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_result_server,
   output logic [63:0] rsp_result_key,
   output logic        rsp_removed_count,
   output logic [1:0]  rsp_status,
   output logic [10:0] rsp_entry_count
);

   localparam int IW = chrt_pkg::IDX_W;
   localparam int CW = chrt_pkg::CNT_W;

   typedef enum logic [3:0] {
      S_IDLE, S_PROBE, S_WAIT, S_CHECK, S_DECIDE, S_RD, S_RDW, S_WR, S_LKRD,
      S_LKW, S_LKDONE, S_RESP
   } state_type;

   state_type            state_ff;
   chrt_pkg::cmd_type    cmd_ff;
   logic [63:0]          key_ff;
   logic [7:0]           srv_ff;
   logic [CW-1:0]        count_ff;
   logic [CW-1:0]        lo_ff, hi_ff;
   logic [CW-1:0]        ptr_ff;
   logic [7:0]           r_server_ff;
   logic [63:0]          r_key_ff;
   logic                 r_removed_ff;
   chrt_pkg::status_type r_status_ff;
   logic                 ram_we;
   logic [IW-1:0]        ram_addr;
   logic [chrt_pkg::ENTRY_W-1:0] ram_wdata, ram_rdata, hold_ff;
   logic [CW-1:0]        mid;
   logic                 hit;

   chrt_ram #(.WIDTH(chrt_pkg::ENTRY_W), .DEPTH(chrt_pkg::CAPACITY)) u_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .addr    (ram_addr),
      .wr_data (ram_wdata),
      .rd_data (ram_rdata)
   );

   assign mid = lo_ff + ((hi_ff - lo_ff) >> 1);
   // entry at search position matches the key
   assign hit = (lo_ff < count_ff) && (ram_rdata[71:8] == key_ff);

   // ram port control, shift reads the neighbor entry
   always_comb begin
      ram_we    = 1'b0;
      ram_addr  = ptr_ff[IW-1:0];
      ram_wdata = hold_ff;
      case (state_ff)
         S_PROBE:  ram_addr = mid[IW-1:0];
         S_RD: begin
            ram_addr = (cmd_ff == chrt_pkg::CMD_INSERT) ? ptr_ff[IW-1:0] - 1'b1
                                                        : ptr_ff[IW-1:0] + 1'b1;
         end
         S_WR:     ram_we = 1'b1;
         default:  ram_addr = ptr_ff[IW-1:0];
      endcase
   end

   assign req_stall         = (state_ff != S_IDLE);
   assign rsp_valid         = (state_ff == S_RESP);
   assign rsp_result_server = r_server_ff;
   assign rsp_result_key    = r_key_ff;
   assign rsp_removed_count = r_removed_ff;
   assign rsp_status        = r_status_ff;
   assign rsp_entry_count   = count_ff;

   // sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
      end else begin
         case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  cmd_ff       <= chrt_pkg::cmd_type'(req_command);
                  key_ff       <= req_key_hash;
                  srv_ff       <= req_server_id;
                  lo_ff        <= '0;
                  hi_ff        <= count_ff;
                  r_server_ff  <= '0;
                  r_key_ff     <= '0;
                  r_removed_ff <= 1'b0;
                  r_status_ff  <= chrt_pkg::ST_OK;
                  state_ff     <= S_PROBE;
               end
            end
            // binary search, one probe per ram read
            S_PROBE: begin
               if (lo_ff < hi_ff) begin
                  ptr_ff   <= mid;
                  state_ff <= S_WAIT;
               end else begin
                  ptr_ff   <= lo_ff;
                  state_ff <= S_CHECK;
               end
            end
            S_WAIT: begin
               if (ram_rdata[71:8] < key_ff) lo_ff <= ptr_ff + 1'b1;
               else hi_ff <= ptr_ff;
               state_ff <= S_PROBE;
            end
            S_CHECK: state_ff <= S_DECIDE;
            // act on the search position
            S_DECIDE: begin
               state_ff <= S_RESP;
               case (cmd_ff)
                  chrt_pkg::CMD_INSERT: begin
                     if (key_ff == '0) begin
                        r_status_ff <= chrt_pkg::ST_ZERO;
                     end else if (hit) begin
                        hold_ff  <= {key_ff, srv_ff};
                        ptr_ff   <= lo_ff;
                        lo_ff    <= lo_ff;
                        state_ff <= S_WR;
                     end else if (count_ff >= CW'(chrt_pkg::CAPACITY)) begin
                        r_status_ff <= chrt_pkg::ST_FULL;
                     end else begin
                        // shift up from the top, then place the key
                        ptr_ff   <= count_ff;
                        count_ff <= count_ff + 1'b1;
                        state_ff <= S_RD;
                     end
                  end
                  chrt_pkg::CMD_REMOVE: begin
                     if (key_ff != '0 && hit) begin
                        r_removed_ff <= 1'b1;
                        count_ff     <= count_ff - 1'b1;
                        ptr_ff       <= lo_ff;
                        state_ff     <= S_RD;
                     end
                  end
                  chrt_pkg::CMD_FIND: begin
                     if (key_ff != '0 && hit) r_key_ff <= key_ff;
                  end
                  default: begin
                     if (count_ff == '0) begin
                        r_status_ff <= chrt_pkg::ST_EMPTY;
                     end else if (lo_ff >= count_ff) begin
                        ptr_ff   <= '0;
                        state_ff <= S_LKRD;
                     end else begin
                        r_server_ff <= ram_rdata[7:0];
                     end
                  end
               endcase
            end
            // shift: insert reads ptr-1, remove reads ptr+1
            S_RD: begin
               if (cmd_ff == chrt_pkg::CMD_INSERT) begin
                  if (ptr_ff == lo_ff) begin
                     hold_ff  <= {key_ff, srv_ff};
                     state_ff <= S_WR;
                  end else begin
                     ptr_ff   <= ptr_ff - 1'b1;
                     state_ff <= S_RDW;
                  end
               end else begin
                  if (ptr_ff >= count_ff) state_ff <= S_RESP;
                  else begin
                     ptr_ff   <= ptr_ff + 1'b1;
                     state_ff <= S_RDW;
                  end
               end
            end
            S_RDW: begin
               hold_ff  <= ram_rdata;
               ptr_ff   <= (cmd_ff == chrt_pkg::CMD_INSERT) ? ptr_ff + 1'b1
                                                            : ptr_ff - 1'b1;
               state_ff <= S_WR;
            end
            S_WR: begin
               if (cmd_ff == chrt_pkg::CMD_INSERT) begin
                  if (ptr_ff == lo_ff) state_ff <= S_RESP;
                  else begin
                     ptr_ff   <= ptr_ff - 1'b1;
                     state_ff <= S_RD;
                  end
               end else begin
                  ptr_ff   <= ptr_ff + 1'b1;
                  state_ff <= S_RD;
               end
            end
            // wrapped lookup reads entry zero
            S_LKRD: state_ff <= S_LKW;
            S_LKW:  state_ff <= S_LKDONE;
            S_LKDONE: begin
               r_server_ff <= ram_rdata[7:0];
               state_ff    <= S_RESP;
            end
            S_RESP: begin
               if (!rsp_stall) state_ff <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

endmodule

@@ tb/sv/consistent_hash_ring_table_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// consistent_hash_ring_table_test
// self-checking bench for the sorted hash ring table
// ----------------------------------------------------------------------------
// A short table of directed transactions covers the empty table, key zero,
// the extreme keys, overwrite and wrap-around. A block of ascending points
// is then loaded, the receiver holding off at its start; the first point is
// removed so that the whole block moves down. Random traffic on a small key
// pool follows. Responses are checked against table rows or a queue-based
// model of the ring, with random idling and stalls on both channels.
// ----------------------------------------------------------------------------
module consistent_hash_ring_table_test;

   localparam int QUIET_LIMIT = 20000;
   localparam int HOLD_CYCLES = 300;
   localparam int RANDOM_ITEMS = 510;
   localparam int BLOCK_POINTS = 64;

   typedef struct {
      logic [7:0]  server;
      logic [63:0] key;
      logic        removed;
      logic [1:0]  status;
      logic [10:0] count;
   } ring_rsp_type;

   typedef struct {
      logic [63:0] key;
      logic [7:0]  srv;
   } ring_point_type;

   typedef struct {
      chrt_pkg::cmd_type cmd;
      logic [63:0]       key;
      logic [7:0]        srv;
      bit                typed;
      ring_rsp_type      rsp;
   } dir_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [1:0]  req_command = '0;
   logic [63:0] req_key_hash = '0;
   logic [7:0]  req_server_id = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [7:0]  rsp_result_server;
   logic [63:0] rsp_result_key;
   logic        rsp_removed_count;
   logic [1:0]  rsp_status;
   logic [10:0] rsp_entry_count;

   ring_point_type ring_pts[$];
   ring_rsp_type   pending_rsp[$];
   logic [63:0]    key_pool[48];
   int             fail_count = 0;
   int             items_sent = 0;
   int             rsp_seen = 0;
   int             peak_points = 0;
   int             quiet_cycles = 0;
   int             hold_left = 0;
   bit             hold_req = 0;
   bit             idle_on = 1;

   consistent_hash_ring_table dut (.*);

   // clock
   always begin
      clock = 1'b1;
      #2;
      clock = 1'b0;
      #2;
   end

   // ring model: applies one command, returns the response it gives
   function automatic ring_rsp_type ring_apply(chrt_pkg::cmd_type c, logic [63:0] k,
                                               logic [7:0] s);
      ring_rsp_type   r;
      ring_point_type p;
      int             pos;
      bit             hit;
      r.server = '0;
      r.key = '0;
      r.removed = 1'b0;
      r.status = chrt_pkg::ST_OK;
      pos = 0;
      while (pos < ring_pts.size() && ring_pts[pos].key < k) pos++;
      hit = (k != 0) && (pos < ring_pts.size()) && (ring_pts[pos].key == k);
      case (c)
         chrt_pkg::CMD_INSERT: begin
            p.key = k;
            p.srv = s;
            if (k == 0) r.status = chrt_pkg::ST_ZERO;
            else if (hit) ring_pts[pos].srv = s;
            else if (ring_pts.size() >= chrt_pkg::CAPACITY) r.status = chrt_pkg::ST_FULL;
            else ring_pts.insert(pos, p);
         end
         chrt_pkg::CMD_REMOVE: begin
            if (hit) begin
               ring_pts.delete(pos);
               r.removed = 1'b1;
            end
         end
         chrt_pkg::CMD_FIND: begin
            if (hit) r.key = k;
         end
         default: begin
            if (ring_pts.size() == 0) r.status = chrt_pkg::ST_EMPTY;
            else r.server = (pos >= ring_pts.size()) ? ring_pts[0].srv : ring_pts[pos].srv;
         end
      endcase
      r.count = 11'(ring_pts.size());
      if (ring_pts.size() > peak_points) peak_points = ring_pts.size();
      return r;
   endfunction

   // offer one transaction, wait for acceptance, record the expected response
   task automatic send_item(chrt_pkg::cmd_type c, logic [63:0] k, logic [7:0] s,
                            bit typed = 0, ring_rsp_type typed_rsp = '{default: '0});
      ring_rsp_type r;
      if (idle_on && $urandom_range(99) < 7) begin
         @(negedge clock);
         req_valid = 1'b0;
         repeat ($urandom_range(3)) @(negedge clock);
      end
      @(negedge clock);
      req_valid = 1'b1;
      req_command = c;
      req_key_hash = k;
      req_server_id = s;
      do @(posedge clock); while (req_stall);
      r = ring_apply(c, k, s);
      pending_rsp.push_back(typed ? typed_rsp : r);
      items_sent++;
   endtask

   // sender stops until all responses are back
   task automatic drain_responses();
      @(negedge clock);
      req_valid = 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
   endtask

   // receiver stall, with an occasional long hold-off
   always @(negedge clock) begin
      if (hold_left > 0) begin
         rsp_stall = 1'b1;
         hold_left--;
      end else if (hold_req) begin
         hold_req = 0;
         hold_left = HOLD_CYCLES - 1;
         rsp_stall = 1'b1;
      end else begin
         rsp_stall = idle_on && ($urandom_range(99) < 7);
      end
   end

   // response checker
   always @(posedge clock) begin
      ring_rsp_type e;
      if (!reset && rsp_valid && !rsp_stall) begin
         rsp_seen++;
         if (pending_rsp.size() == 0) begin
            $display("%0t: response with none expected: srv %h key %h rm %b st %0d cnt %0d",
                     $time, rsp_result_server, rsp_result_key, rsp_removed_count,
                     rsp_status, rsp_entry_count);
            fail_count++;
         end else begin
            e = pending_rsp.pop_front();
            if (rsp_result_server !== e.server || rsp_result_key !== e.key ||
                rsp_removed_count !== e.removed || rsp_status !== e.status ||
                rsp_entry_count !== e.count) begin
               $display("%0t: mismatch expected srv %h key %h rm %b st %0d cnt %0d",
                        $time, e.server, e.key, e.removed, e.status, e.count);
               $display("%0t:          actual   srv %h key %h rm %b st %0d cnt %0d",
                        $time, rsp_result_server, rsp_result_key, rsp_removed_count,
                        rsp_status, rsp_entry_count);
               fail_count++;
            end
         end
      end
   end

   // watchdog on cycles without any transaction
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("%0t: no progress for %0d cycles", $time, QUIET_LIMIT);
         $display("Regression FAIL");
         $finish;
      end
   end

   // stimulus
   initial begin
      dir_row_type dir_rows[$];
      logic [63:0] k;
      int pick;
      chrt_pkg::cmd_type c;

      dir_rows = '{
         '{chrt_pkg::CMD_LOOKUP, 64'd5, 8'd0, 1,
           '{8'd0, 64'd0, 1'b0, chrt_pkg::ST_EMPTY, 11'd0}},
         '{chrt_pkg::CMD_FIND, 64'd0, 8'd0, 1,
           '{8'd0, 64'd0, 1'b0, chrt_pkg::ST_OK, 11'd0}},
         '{chrt_pkg::CMD_INSERT, 64'd0, 8'd9, 1,
           '{8'd0, 64'd0, 1'b0, chrt_pkg::ST_ZERO, 11'd0}},
         '{chrt_pkg::CMD_REMOVE, 64'd0, 8'd0, 1,
           '{8'd0, 64'd0, 1'b0, chrt_pkg::ST_OK, 11'd0}},
         '{chrt_pkg::CMD_INSERT, '1, 8'hFF, 1,
           '{8'd0, 64'd0, 1'b0, chrt_pkg::ST_OK, 11'd1}},
         '{chrt_pkg::CMD_INSERT, 64'd1, 8'h00, 1,
           '{8'd0, 64'd0, 1'b0, chrt_pkg::ST_OK, 11'd2}},
         '{chrt_pkg::CMD_LOOKUP, 64'd0, 8'd0, 1,
           '{8'h00, 64'd0, 1'b0, chrt_pkg::ST_OK, 11'd2}},
         '{chrt_pkg::CMD_LOOKUP, '1, 8'd0, 1,
           '{8'hFF, 64'd0, 1'b0, chrt_pkg::ST_OK, 11'd2}},
         '{chrt_pkg::CMD_FIND, '1, 8'd0, 1,
           '{8'h00, '1, 1'b0, chrt_pkg::ST_OK, 11'd2}},
         '{chrt_pkg::CMD_INSERT, '1, 8'h5A, 1,
           '{8'd0, 64'd0, 1'b0, chrt_pkg::ST_OK, 11'd2}},
         '{chrt_pkg::CMD_LOOKUP, 64'd2, 8'd0, 1,
           '{8'h5A, 64'd0, 1'b0, chrt_pkg::ST_OK, 11'd2}},
         '{chrt_pkg::CMD_REMOVE, 64'd7, 8'd0, 1,
           '{8'd0, 64'd0, 1'b0, chrt_pkg::ST_OK, 11'd2}},
         '{chrt_pkg::CMD_REMOVE, '1, 8'd0, 1,
           '{8'd0, 64'd0, 1'b1, chrt_pkg::ST_OK, 11'd1}},
         '{chrt_pkg::CMD_LOOKUP, 64'h8000_0000_0000_0000, 8'd0, 1,
           '{8'h00, 64'd0, 1'b0, chrt_pkg::ST_OK, 11'd1}},
         '{chrt_pkg::CMD_FIND, '1, 8'd0, 1,
           '{8'd0, 64'd0, 1'b0, chrt_pkg::ST_OK, 11'd1}},
         '{chrt_pkg::CMD_INSERT, 64'h8000_0000_0000_0000, 8'hA5, 0, '{default: '0}},
         '{chrt_pkg::CMD_INSERT, 64'h0123_4567_89AB_CDEF, 8'h03, 0, '{default: '0}},
         '{chrt_pkg::CMD_LOOKUP, 64'h4000_0000_0000_0000, 8'd0, 0, '{default: '0}},
         '{chrt_pkg::CMD_FIND, 64'h0123_4567_89AB_CDEF, 8'd0, 0, '{default: '0}},
         '{chrt_pkg::CMD_REMOVE, 64'd1, 8'd0, 0, '{default: '0}}
      };

      foreach (key_pool[i]) key_pool[i] = {$urandom, $urandom};

      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed table
      foreach (dir_rows[i])
         send_item(dir_rows[i].cmd, dir_rows[i].key, dir_rows[i].srv,
                   dir_rows[i].typed, dir_rows[i].rsp);
      drain_responses();

      // block of ascending points, receiver held off at its start
      hold_req = 1;
      k = 64'hC000_0000_0000_0000;
      for (int n = 0; n < BLOCK_POINTS; n++) begin
         send_item(chrt_pkg::CMD_INSERT, k, 8'($urandom));
         k += 64'h1_0000;
      end
      send_item(chrt_pkg::CMD_INSERT, 64'h10, 8'h77);
      send_item(chrt_pkg::CMD_LOOKUP, '1, 8'd0);
      send_item(chrt_pkg::CMD_FIND, 64'hC000_0000_0000_0000, 8'd0);
      // removing the lowest block point moves every point above it
      send_item(chrt_pkg::CMD_REMOVE, 64'hC000_0000_0000_0000, 8'd0);
      send_item(chrt_pkg::CMD_LOOKUP, 64'hB000_0000_0000_0000, 8'd0);
      drain_responses();

      // random traffic, mostly on the key pool
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         idle_on = !(n >= 200 && n < 330);
         if (n == 400) hold_req = 1;
         pick = $urandom_range(99);
         c = (pick < 25) ? chrt_pkg::CMD_INSERT : (pick < 42) ? chrt_pkg::CMD_REMOVE :
             (pick < 60) ? chrt_pkg::CMD_FIND : chrt_pkg::CMD_LOOKUP;
         if (c == chrt_pkg::CMD_LOOKUP || $urandom_range(9) == 0) k = {$urandom, $urandom};
         else k = key_pool[$urandom_range(47)];
         if ($urandom_range(49) == 0) k = '0;
         send_item(c, k, 8'($urandom));
      end
      drain_responses();
      repeat (50) @(posedge clock);

      $display("covered %0d transactions, %0d responses, up to %0d points in the ring",
               items_sent, rsp_seen, peak_points);
      if (fail_count == 0 && pending_rsp.size() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

@@ filelist.f @@
design/chrt_pkg.sv
design/chrt_ram.sv
design/consistent_hash_ring_table.sv
tb/sv/consistent_hash_ring_table_test.sv
